[design/fir_complementary_crossover_unit_macros.svh]
// assertion macros shared by the crossover rtl
// no dependencies; included by the modules that carry assertions
`ifndef FIR_COMPLEMENTARY_CROSSOVER_UNIT_MACROS_SVH
`define FIR_COMPLEMENTARY_CROSSOVER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define FCC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("fcc assertion failed");
`define FCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fcc assertion failed");
`else
`define FCC_ASSERT(lbl, clk, rst, prop)
`define FCC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[design/fcc_pkg.sv]
// shared types and constants for the fir complementary crossover
// no dependencies
`timescale 1ns / 1ps

package fcc_pkg;

   localparam int MAX_TAPS_DEF    = 8192;
   localparam int SAMPLE_BITS_DEF = 24;
   localparam int COEF_BITS_DEF   = 32;

   localparam int TAP_COUNT_BITS  = 13;
   localparam int COEF_INDEX_BITS = 13;
   localparam int CSR_DATA_BITS   = 32;
   localparam int CSR_ADDR_BITS   = 2;

   localparam logic [CSR_ADDR_BITS-1:0]  CSR_TAP_COUNT_ADDR = '0;
   localparam logic [TAP_COUNT_BITS-1:0] TAP_COUNT_RESET    = 13'd4097;

   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_LOAD   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_ROUND,
      ST_DONE
   } fcc_state_type;

   typedef struct packed {
      logic take_sample;
      logic take_coef;
      logic issue;
      logic round;
      logic load_out;
   } fcc_cmd_type;

   typedef struct packed {
      logic last_tap;
      logic pipe_busy;
      logic out_free;
   } fcc_stat_type;

endpackage

[design/fcc_if.sv]
// valid/ready channel interfaces for sample/load requests and band results
// depends on fcc_pkg
`timescale 1ns / 1ps

interface fcc_req_if #(
   parameter int SAMPLE_BITS = fcc_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = fcc_pkg::COEF_BITS_DEF
) ();
   logic                                 valid;
   logic                                 ready;
   logic                                 func;
   logic signed [SAMPLE_BITS-1:0]        left_sample;
   logic signed [SAMPLE_BITS-1:0]        right_sample;
   logic [fcc_pkg::COEF_INDEX_BITS-1:0]  coef_index;
   logic signed [COEF_BITS-1:0]          coef_value;

   modport source (output valid, func, left_sample, right_sample, coef_index, coef_value,
                   input ready);
   modport sink (input valid, func, left_sample, right_sample, coef_index, coef_value,
                 output ready);
endinterface

interface fcc_rsp_if #(
   parameter int SAMPLE_BITS = fcc_pkg::SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] low_left;
   logic signed [SAMPLE_BITS-1:0] low_right;
   logic signed [SAMPLE_BITS-1:0] high_left;
   logic signed [SAMPLE_BITS-1:0] high_right;

   modport source (output valid, low_left, low_right, high_left, high_right, input ready);
   modport sink (input valid, low_left, low_right, high_left, high_right, output ready);
endinterface

[design/fcc_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module fcc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[design/fcc_ctrl.sv]
// controller state machine: sequences accept, tap walk, drain, rounding, output
// depends on fcc_pkg and the macros header
`timescale 1ns / 1ps
`include "fir_complementary_crossover_unit_macros.svh"

module fcc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_func,
   output logic                  req_ready,
   input  fcc_pkg::fcc_stat_type stat,
   output fcc_pkg::fcc_cmd_type  cmd
);

   fcc_pkg::fcc_state_type state_ff;
   fcc_pkg::fcc_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fcc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fcc_pkg::ST_IDLE: begin
            if (req_valid && req_func == fcc_pkg::FUNC_SAMPLE) begin
               state_in = fcc_pkg::ST_MAC;
            end
         end
         fcc_pkg::ST_MAC: begin
            if (stat.last_tap) begin
               state_in = fcc_pkg::ST_DRAIN;
            end
         end
         fcc_pkg::ST_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = fcc_pkg::ST_ROUND;
            end
         end
         fcc_pkg::ST_ROUND: begin
            state_in = fcc_pkg::ST_DONE;
         end
         fcc_pkg::ST_DONE: begin
            if (stat.out_free) begin
               state_in = fcc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fcc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready       = 1'b0;
      cmd             = '0;
      case (state_ff)
         fcc_pkg::ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.take_sample = req_valid && req_func == fcc_pkg::FUNC_SAMPLE;
            cmd.take_coef   = req_valid && req_func == fcc_pkg::FUNC_LOAD;
         end
         fcc_pkg::ST_MAC: begin
            cmd.issue = 1'b1;
         end
         fcc_pkg::ST_ROUND: begin
            cmd.round = 1'b1;
         end
         fcc_pkg::ST_DONE: begin
            cmd.load_out = stat.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   `FCC_ASSERT_NEXT(a_last_tap_drains, clock, reset,
      state_ff == fcc_pkg::ST_MAC && stat.last_tap, state_ff == fcc_pkg::ST_DRAIN)
   `FCC_ASSERT(a_round_after_drain, clock, reset,
      state_ff != fcc_pkg::ST_ROUND || !stat.pipe_busy)
   `FCC_ASSERT_NEXT(a_sample_starts_walk, clock, reset,
      cmd.take_sample, state_ff == fcc_pkg::ST_MAC && !req_ready)

endmodule

[design/fcc_datapath.sv]
// datapath: history and coefficient memories, two mac lanes, rounding, output register
// depends on fcc_pkg, fcc_ram and the macros header
`timescale 1ns / 1ps
`include "fir_complementary_crossover_unit_macros.svh"

module fcc_datapath #(
   parameter int MAX_TAPS    = fcc_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_BITS = fcc_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = fcc_pkg::COEF_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fcc_pkg::fcc_cmd_type                cmd,
   output fcc_pkg::fcc_stat_type               stat,
   input  logic signed [SAMPLE_BITS-1:0]       left_sample,
   input  logic signed [SAMPLE_BITS-1:0]       right_sample,
   input  logic [fcc_pkg::COEF_INDEX_BITS-1:0] coef_index,
   input  logic signed [COEF_BITS-1:0]         coef_value,
   input  logic [fcc_pkg::TAP_COUNT_BITS-1:0]  tap_count,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic signed [SAMPLE_BITS-1:0]       low_left,
   output logic signed [SAMPLE_BITS-1:0]       low_right,
   output logic signed [SAMPLE_BITS-1:0]       high_left,
   output logic signed [SAMPLE_BITS-1:0]       high_right
);

   localparam int AW     = $clog2(MAX_TAPS);
   localparam int TW     = $clog2(MAX_TAPS + 1);
   localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_W  = PROD_W + AW + 1;
   localparam int SH_W   = ACC_W - COEF_BITS + 1;

   localparam logic [AW-1:0]          LAST_ADDR = AW'(MAX_TAPS - 1);
   localparam logic [TW-1:0]          FULL_FILL = TW'(MAX_TAPS);
   localparam logic [SAMPLE_BITS-1:0] SAT_MAX   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] SAT_MIN   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   function automatic logic [SAMPLE_BITS-1:0] round_sat(input logic [ACC_W-1:0] a);
      logic [ACC_W-1:0]            r;
      logic [SH_W-1:0]             sh;
      logic [SH_W-SAMPLE_BITS:0]   top;
      r   = a + (ACC_W'(1) << (COEF_BITS - 2));
      sh  = r[ACC_W-1:COEF_BITS-1];
      top = sh[SH_W-1:SAMPLE_BITS-1];
      if ((&top) || !(|top)) begin
         return sh[SAMPLE_BITS-1:0];
      end else if (sh[SH_W-1]) begin
         return SAT_MIN;
      end else begin
         return SAT_MAX;
      end
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] diff_sat(input logic [SAMPLE_BITS-1:0] x,
                                                       input logic [SAMPLE_BITS-1:0] y);
      logic [SAMPLE_BITS:0] d;
      d = {x[SAMPLE_BITS-1], x} - {y[SAMPLE_BITS-1], y};
      if (d[SAMPLE_BITS] != d[SAMPLE_BITS-1]) begin
         return d[SAMPLE_BITS] ? SAT_MIN : SAT_MAX;
      end else begin
         return d[SAMPLE_BITS-1:0];
      end
   endfunction

   // write side and fill tracking
   logic [AW-1:0] wpos_ff, wpos_in;
   logic [TW-1:0] fill_ff, fill_in;

   // tap walk
   logic [AW-1:0] raddr_ff, raddr_in;
   logic [AW-1:0] k_ff, k_in;
   logic [AW-1:0] taps_m1_ff, taps_m1_in;
   logic [AW-1:0] delay_ff, delay_in;
   logic [AW-1:0] taps_m1_eff;

   // pipeline
   logic v1_ff, v1_in, zero1_ff, zero1_in, dly1_ff, dly1_in, v2_ff, v2_in;
   logic [PROD_W-1:0] prod_l_ff, prod_l_in, prod_r_ff, prod_r_in;
   logic [ACC_W-1:0]  acc_l_ff, acc_l_in, acc_r_ff, acc_r_in;
   logic [SAMPLE_BITS-1:0] dly_l_ff, dly_l_in, dly_r_ff, dly_r_in;
   logic [SAMPLE_BITS-1:0] low_l_ff, low_l_in, low_r_ff, low_r_in;

   // output register
   logic out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0] out_ll_ff, out_ll_in, out_lr_ff, out_lr_in;
   logic [SAMPLE_BITS-1:0] out_hl_ff, out_hl_in, out_hr_ff, out_hr_in;

   logic                   coef_we;
   logic [COEF_BITS-1:0]   coef_rdata;
   logic [SAMPLE_BITS-1:0] hist_l_rdata, hist_r_rdata;
   logic [SAMPLE_BITS-1:0] hs_l, hs_r;

   assign coef_we = cmd.take_coef && (32'(coef_index) < 32'(MAX_TAPS));

   fcc_ram #(.WIDTH(COEF_BITS), .DEPTH(MAX_TAPS)) u_coef_ram (
      .clock (clock),
      .we    (coef_we),
      .waddr (AW'(coef_index)),
      .wdata (coef_value),
      .raddr (k_ff),
      .rdata (coef_rdata)
   );

   fcc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_hist_l_ram (
      .clock (clock),
      .we    (cmd.take_sample),
      .waddr (wpos_ff),
      .wdata (left_sample),
      .raddr (raddr_ff),
      .rdata (hist_l_rdata)
   );

   fcc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_hist_r_ram (
      .clock (clock),
      .we    (cmd.take_sample),
      .waddr (wpos_ff),
      .wdata (right_sample),
      .raddr (raddr_ff),
      .rdata (hist_r_rdata)
   );

   always_comb begin
      if (tap_count == '0) begin
         taps_m1_eff = '0;
      end else if (32'(tap_count) > 32'(MAX_TAPS)) begin
         taps_m1_eff = LAST_ADDR;
      end else begin
         taps_m1_eff = AW'(32'(tap_count) - 32'd1);
      end
   end

   always_comb begin
      wpos_in    = wpos_ff;
      fill_in    = fill_ff;
      raddr_in   = raddr_ff;
      k_in       = k_ff;
      taps_m1_in = taps_m1_ff;
      delay_in   = delay_ff;
      if (cmd.take_sample) begin
         wpos_in    = (wpos_ff == LAST_ADDR) ? '0 : wpos_ff + 1'b1;
         fill_in    = (fill_ff == FULL_FILL) ? fill_ff : fill_ff + 1'b1;
         raddr_in   = wpos_ff;
         k_in       = '0;
         taps_m1_in = taps_m1_eff;
         delay_in   = taps_m1_eff >> 1;
      end else if (cmd.issue) begin
         raddr_in = (raddr_ff == '0) ? LAST_ADDR : raddr_ff - 1'b1;
         if (k_ff != taps_m1_ff) begin
            k_in = k_ff + 1'b1;
         end
      end
   end

   // entries never written since reset read as zero
   assign hs_l = zero1_ff ? '0 : hist_l_rdata;
   assign hs_r = zero1_ff ? '0 : hist_r_rdata;

   always_comb begin
      v1_in     = cmd.issue;
      zero1_in  = TW'(k_ff) >= fill_ff;
      dly1_in   = cmd.issue && (k_ff == delay_ff);
      v2_in     = v1_ff;
      prod_l_in = {{SAMPLE_BITS{coef_rdata[COEF_BITS-1]}}, coef_rdata}
                * {{COEF_BITS{hs_l[SAMPLE_BITS-1]}}, hs_l};
      prod_r_in = {{SAMPLE_BITS{coef_rdata[COEF_BITS-1]}}, coef_rdata}
                * {{COEF_BITS{hs_r[SAMPLE_BITS-1]}}, hs_r};
      dly_l_in  = dly1_ff ? hs_l : dly_l_ff;
      dly_r_in  = dly1_ff ? hs_r : dly_r_ff;
      acc_l_in  = acc_l_ff;
      acc_r_in  = acc_r_ff;
      if (cmd.take_sample) begin
         acc_l_in = '0;
         acc_r_in = '0;
      end else if (v2_ff) begin
         acc_l_in = acc_l_ff + {{(ACC_W-PROD_W){prod_l_ff[PROD_W-1]}}, prod_l_ff};
         acc_r_in = acc_r_ff + {{(ACC_W-PROD_W){prod_r_ff[PROD_W-1]}}, prod_r_ff};
      end
      low_l_in = cmd.round ? round_sat(acc_l_ff) : low_l_ff;
      low_r_in = cmd.round ? round_sat(acc_r_ff) : low_r_ff;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_ll_in    = out_ll_ff;
      out_lr_in    = out_lr_ff;
      out_hl_in    = out_hl_ff;
      out_hr_in    = out_hr_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
         out_ll_in    = low_l_ff;
         out_lr_in    = low_r_ff;
         out_hl_in    = diff_sat(dly_l_ff, low_l_ff);
         out_hr_in    = diff_sat(dly_r_ff, low_r_ff);
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff      <= '0;
         fill_ff      <= '0;
         k_ff         <= '0;
         taps_m1_ff   <= '0;
         v1_ff        <= 1'b0;
         dly1_ff      <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         wpos_ff      <= wpos_in;
         fill_ff      <= fill_in;
         k_ff         <= k_in;
         taps_m1_ff   <= taps_m1_in;
         v1_ff        <= v1_in;
         dly1_ff      <= dly1_in;
         v2_ff        <= v2_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raddr_ff  <= raddr_in;
      delay_ff  <= delay_in;
      zero1_ff  <= zero1_in;
      prod_l_ff <= prod_l_in;
      prod_r_ff <= prod_r_in;
      acc_l_ff  <= acc_l_in;
      acc_r_ff  <= acc_r_in;
      dly_l_ff  <= dly_l_in;
      dly_r_ff  <= dly_r_in;
      low_l_ff  <= low_l_in;
      low_r_ff  <= low_r_in;
      out_ll_ff <= out_ll_in;
      out_lr_ff <= out_lr_in;
      out_hl_ff <= out_hl_in;
      out_hr_ff <= out_hr_in;
   end

   assign stat.last_tap  = k_ff == taps_m1_ff;
   assign stat.pipe_busy = v1_ff || v2_ff;
   assign stat.out_free  = !out_valid_ff || rsp_ready;

   assign rsp_valid  = out_valid_ff;
   assign low_left   = out_ll_ff;
   assign low_right  = out_lr_ff;
   assign high_left  = out_hl_ff;
   assign high_right = out_hr_ff;

   `FCC_ASSERT(a_fill_bounded, clock, reset, fill_ff <= FULL_FILL)
   `FCC_ASSERT(a_walk_bounded, clock, reset, k_ff <= taps_m1_ff)

endmodule

[design/fir_complementary_crossover_unit.sv]
// top level of the two-channel linear-phase fir crossover: csr, controller, datapath
// depends on fcc_pkg, fcc_if, fcc_ctrl and fcc_datapath
//
//   channel   kind         direction  carries
//   req_ch    valid/ready  in         sample pair or coefficient load
//   rsp_ch    valid/ready  out        low and high band per channel
//   csr_*     apb          in/out     tap_count at byte address 0
//
// a sample pair walks the effective taps (from tap_count) with one
// multiply-accumulate per channel per tap on the single read port of each memory
// a coefficient load is taken in the idle state and gives no result
// after reset history reads as zero through a fill count, no clearing pass;
// coefficients are undefined until loaded
// a stalled result holds in the output register; a finished result waits in the rounding register until it is free
`timescale 1ns / 1ps

module fir_complementary_crossover_unit #(
   parameter int MAX_TAPS    = fcc_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_BITS = fcc_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = fcc_pkg::COEF_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   fcc_req_if.sink                           req_ch,
   fcc_rsp_if.source                         rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fcc_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [fcc_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [fcc_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);

   logic [fcc_pkg::TAP_COUNT_BITS-1:0] tap_count_ff, tap_count_in;
   logic                               csr_write;

   fcc_pkg::fcc_cmd_type  cmd;
   fcc_pkg::fcc_stat_type stat;

   // single register: tap_count at byte address 0
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                    && (csr_paddr == fcc_pkg::CSR_TAP_COUNT_ADDR);

   always_comb begin
      tap_count_in = tap_count_ff;
      if (csr_write) begin
         tap_count_in = csr_pwdata[fcc_pkg::TAP_COUNT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= fcc_pkg::TAP_COUNT_RESET;
      end else begin
         tap_count_ff <= tap_count_in;
      end
   end

   assign csr_prdata = fcc_pkg::CSR_DATA_BITS'(tap_count_ff);

   fcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_func  (req_ch.func),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fcc_datapath #(
      .MAX_TAPS    (MAX_TAPS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .left_sample  (req_ch.left_sample),
      .right_sample (req_ch.right_sample),
      .coef_index   (req_ch.coef_index),
      .coef_value   (req_ch.coef_value),
      .tap_count    (tap_count_ff),
      .rsp_ready    (rsp_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .low_left     (rsp_ch.low_left),
      .low_right    (rsp_ch.low_right),
      .high_left    (rsp_ch.high_left),
      .high_right   (rsp_ch.high_right)
   );

endmodule

[test/fcc_band_checker.sv]
// band checker for the fir complementary crossover: watches the request, result and csr ports,
// predicts low and high bands per sample pair and compares every result transaction
// depends on fcc_pkg and fcc_if
`timescale 1ns / 1ps

module fcc_band_checker #(
   parameter logic [fcc_pkg::CSR_ADDR_BITS-1:0] TAP_COUNT_ADDR = '0
) (
   input  logic                              clock,
   input  logic                              reset,
   fcc_req_if                                req_mon,
   fcc_rsp_if                                rsp_mon,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic                              csr_pready,
   input  logic [fcc_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [fcc_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output int                                error_count,
   output int                                outstanding
);
   import fcc_pkg::*;

   localparam int DEPTH    = MAX_TAPS_DEF;
   localparam int SB       = SAMPLE_BITS_DEF;
   localparam int CB       = COEF_BITS_DEF;
   localparam int ACC_BITS = 80;
   localparam logic signed [ACC_BITS-1:0] SAMPLE_MAX = (80'sd1 <<< (SB - 1)) - 80'sd1;
   localparam logic signed [ACC_BITS-1:0] SAMPLE_MIN = -(80'sd1 <<< (SB - 1));
   localparam logic signed [ACC_BITS-1:0] ROUND_HALF = 80'sd1 <<< (CB - 2);

   typedef logic signed [SB-1:0] sample_word;
   typedef struct packed {
      sample_word low_left;
      sample_word low_right;
      sample_word high_left;
      sample_word high_right;
   } band_set;

   sample_word                 left_line [DEPTH];
   sample_word                 right_line [DEPTH];
   logic signed [CB-1:0]       coef_mem [DEPTH];
   logic [TAP_COUNT_BITS-1:0]  tap_setting;
   logic [COEF_INDEX_BITS-1:0] head;
   band_set                    band_queue [$];
   int                         mismatch_total = 0;

   assign error_count = mismatch_total;

   function automatic sample_word clamp_sample(input logic signed [ACC_BITS-1:0] v);
      if (v > SAMPLE_MAX) return SAMPLE_MAX[SB-1:0];
      if (v < SAMPLE_MIN) return SAMPLE_MIN[SB-1:0];
      return v[SB-1:0];
   endfunction

   // newest sample sits at head; coefficient k weighs the sample k pairs back
   function automatic band_set crossover_bands();
      int unsigned                taps;
      int unsigned                delay;
      int unsigned                k;
      logic [COEF_INDEX_BITS-1:0] at;
      logic signed [ACC_BITS-1:0] acc_left;
      logic signed [ACC_BITS-1:0] acc_right;
      logic signed [ACC_BITS-1:0] c_wide;
      logic signed [ACC_BITS-1:0] x_wide;
      sample_word                 low_l;
      sample_word                 low_r;
      band_set                    bands;
      taps = (tap_setting == 0) ? 1 : tap_setting;
      if (taps > DEPTH) taps = DEPTH;
      delay = (taps - 1) / 2;
      acc_left = '0;
      acc_right = '0;
      for (k = 0; k < taps; k++) begin
         at = head - k[COEF_INDEX_BITS-1:0];
         c_wide = coef_mem[k];
         x_wide = left_line[at];
         acc_left = acc_left + c_wide * x_wide;
         x_wide = right_line[at];
         acc_right = acc_right + c_wide * x_wide;
      end
      low_l = clamp_sample((acc_left + ROUND_HALF) >>> (CB - 1));
      low_r = clamp_sample((acc_right + ROUND_HALF) >>> (CB - 1));
      at = head - delay[COEF_INDEX_BITS-1:0];
      bands.low_left = low_l;
      bands.low_right = low_r;
      x_wide = left_line[at];
      c_wide = low_l;
      bands.high_left = clamp_sample(x_wide - c_wide);
      x_wide = right_line[at];
      c_wide = low_r;
      bands.high_right = clamp_sample(x_wide - c_wide);
      return bands;
   endfunction

   task automatic report_mismatch(input string what, input sample_word got,
                                  input sample_word want);
      mismatch_total++;
      $display("%0t band check: %s got %0d, expected %0d", $time, what, got, want);
   endtask

   always @(posedge clock) begin
      band_set want;
      int      i;
      if (reset) begin
         for (i = 0; i < DEPTH; i++) begin
            left_line[i] = '0;
            right_line[i] = '0;
         end
         head = '0;
         tap_setting = TAP_COUNT_RESET;
         band_queue.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == TAP_COUNT_ADDR) begin
            tap_setting = csr_pwdata[TAP_COUNT_BITS-1:0];
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (band_queue.size() == 0) begin
               report_mismatch("result transaction with no sample pending, low_left",
                               rsp_mon.low_left, '0);
            end else begin
               want = band_queue.pop_front();
               if (rsp_mon.low_left !== want.low_left)
                  report_mismatch("low_left", rsp_mon.low_left, want.low_left);
               if (rsp_mon.low_right !== want.low_right)
                  report_mismatch("low_right", rsp_mon.low_right, want.low_right);
               if (rsp_mon.high_left !== want.high_left)
                  report_mismatch("high_left", rsp_mon.high_left, want.high_left);
               if (rsp_mon.high_right !== want.high_right)
                  report_mismatch("high_right", rsp_mon.high_right, want.high_right);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.func == FUNC_LOAD) begin
               coef_mem[req_mon.coef_index] = req_mon.coef_value;
            end else begin
               left_line[head] = req_mon.left_sample;
               right_line[head] = req_mon.right_sample;
               band_queue.push_back(crossover_bands());
               head = head + 1'b1;
            end
         end
      end
      outstanding <= band_queue.size();
   end

endmodule

[test/fir_complementary_crossover_unit_test.sv]
// testbench top for the fir complementary crossover: clock, reset, csr writes and
// request/result traffic with random gaps; verdict from the band checker
// depends on fcc_pkg, fcc_if, fir_complementary_crossover_unit and fcc_band_checker
`timescale 1ns / 1ps

module fir_complementary_crossover_unit_test;
   import fcc_pkg::*;

   localparam logic [CSR_ADDR_BITS-1:0] TAP_COUNT_ADDR = '0;
   localparam int DEPTH         = MAX_TAPS_DEF;
   localparam int LOADED_TAPS   = 40;
   localparam int SETTLE_CYCLES = 16;
   localparam int IDLE_PERCENT  = 15;

   typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_word;
   typedef logic signed [COEF_BITS_DEF-1:0]   coef_word;

   localparam sample_word SAMPLE_MAX = 24'h7FFFFF;
   localparam sample_word SAMPLE_MIN = 24'h800000;
   localparam coef_word   COEF_MAX   = 32'h7FFFFFFF;
   localparam coef_word   COEF_MIN   = 32'h80000000;

   logic                     clock;
   logic                     reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;
   int                       error_count;
   int                       outstanding;
   bit                       idle_on;
   int                       pair_total;
   int                       load_total;

   fcc_req_if req_ch ();
   fcc_rsp_if rsp_ch ();

   fir_complementary_crossover_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   fcc_band_checker #(.TAP_COUNT_ADDR(TAP_COUNT_ADDR)) band_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   initial begin
      #4ms;
      $display("fir_complementary_crossover_unit: mismatch");
      $finish;
   end

   function automatic sample_word rand_sample();
      case ($urandom_range(0, 9))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2, 3, 4: return sample_word'($urandom_range(0, 8191) - 4096);
         default: return sample_word'($urandom);
      endcase
   endfunction

   function automatic coef_word rand_coef();
      case ($urandom_range(0, 9))
         0: return COEF_MAX;
         1: return COEF_MIN;
         2, 3, 4, 5: return $urandom_range(0, 1 << 25) - (1 << 24);
         default: return $urandom;
      endcase
   endfunction

   // returns at the edge where the transaction is taken; valid stays high
   task automatic send_item(input logic f, input sample_word l, input sample_word r,
                            input logic [COEF_INDEX_BITS-1:0] idx, input coef_word val);
      while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func <= f;
      req_ch.left_sample <= l;
      req_ch.right_sample <= r;
      req_ch.coef_index <= idx;
      req_ch.coef_value <= val;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic send_pair(input sample_word l, input sample_word r);
      send_item(FUNC_SAMPLE, l, r, COEF_INDEX_BITS'($urandom), $urandom);
      pair_total++;
   endtask

   task automatic load_coef(input int idx, input coef_word val);
      send_item(FUNC_LOAD, sample_word'($urandom), sample_word'($urandom),
                idx[COEF_INDEX_BITS-1:0], val);
      load_total++;
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic set_taps(input int value);
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= TAP_COUNT_ADDR;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   initial begin
      int i;
      int phase;
      int n;
      reset = 1'b1;
      idle_on = 1'b1;
      pair_total = 0;
      load_total = 0;
      req_ch.valid = 1'b0;
      req_ch.func = FUNC_SAMPLE;
      req_ch.left_sample = '0;
      req_ch.right_sample = '0;
      req_ch.coef_index = '0;
      req_ch.coef_value = '0;
      rsp_ch.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // zero taps acts as one tap, no delay
      set_taps(0);
      load_coef(0, COEF_MAX);
      send_pair(SAMPLE_MAX, SAMPLE_MIN);
      send_pair(SAMPLE_MIN, SAMPLE_MAX);
      send_pair('0, '0);
      send_pair(sample_word'(1), sample_word'(-1));
      // negative full-scale coefficient drives both bands into saturation
      load_coef(0, COEF_MIN);
      send_pair(SAMPLE_MIN, SAMPLE_MIN);
      send_pair(SAMPLE_MAX, SAMPLE_MAX);
      // even tap count, delay rounds down
      set_taps(2);
      load_coef(1, 32'h40000000);
      send_pair(SAMPLE_MAX, SAMPLE_MIN);
      send_pair(sample_word'(12345), sample_word'(-12345));
      set_taps(7);
      for (i = 2; i < 7; i++) load_coef(i, rand_coef());
      load_coef(DEPTH - 1, COEF_MIN);
      repeat (3) send_pair(rand_sample(), rand_sample());

      // rest of the loaded coefficient range and its longest odd filter, no gaps
      idle_on <= 1'b0;
      for (i = 7; i < LOADED_TAPS; i++) load_coef(i, $urandom_range(0, 1 << 17) - (1 << 16));
      set_taps(LOADED_TAPS - 1);
      send_pair(SAMPLE_MAX, SAMPLE_MIN);
      repeat (2) send_pair(rand_sample(), rand_sample());

      for (phase = 0; phase < 6; phase++) begin
         idle_on <= (phase != 4);
         case ($urandom_range(0, 9))
            0: set_taps(0);
            1: set_taps(1);
            2: set_taps($urandom_range(30, LOADED_TAPS));
            default: set_taps($urandom_range(2, LOADED_TAPS - 1));
         endcase
         for (n = 0; n < 14; n++) begin
            if (phase == 3 && n == 12) wait_idle();
            if ($urandom_range(0, 4) == 0)
               load_coef($urandom_range(0, DEPTH - 1), rand_coef());
            else
               send_pair(rand_sample(), rand_sample());
         end
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d sample pairs and %0d coefficient loads", pair_total, load_total);
      $display("tap counts from zero to forty, even counts, saturation, random gaps");
      if (error_count == 0 && outstanding == 0)
         $display("fir_complementary_crossover_unit: match");
      else
         $display("fir_complementary_crossover_unit: mismatch");
      $finish;
   end

endmodule
